// File: hw/rtl/kbd_pkg.sv
`default_nettype none
package kbd_pkg;

    localparam int KEY_SLOTS    = 6;
    localparam int INPUT_SLOTS  = 6;
    localparam int MOD_COUNT    = 8;
    localparam int MOD_W        = $clog2(MOD_COUNT);
    localparam int MOD_BASE     = 224;
    localparam int RESERVED_MAX = 3;

    localparam int SYNC_POS = MOD_COUNT + 2 * KEY_SLOTS;
    localparam int POS_W    = $clog2(SYNC_POS + 1);
    localparam int SLOT_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    localparam int IN_DATA_W  = 8 * (1 + INPUT_SLOTS);
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        EV_KEY     = 2'd0,
        EV_UNKNOWN = 2'd1,
        EV_SYNC    = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        XFER_OK    = 2'd0,
        XFER_STOP  = 2'd1,
        XFER_ERROR = 2'd2
    } xfer_status_t;

    typedef logic [KEY_SLOTS-1:0][7:0] slots_t;

    typedef struct packed {
        logic [7:0]           mods;
        slots_t               old_keys;
        slots_t               new_keys;
        logic [KEY_SLOTS-1:0] rel;
        logic [KEY_SLOTS-1:0] prs;
    } load_t;

    localparam logic [7:0] SCAN_MAP [0:255] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
        8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
        8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
        8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
        8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
        8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
        8'd27,  8'd43,  8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
        8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
        8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd99,  8'd70,
        8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
        8'd105, 8'd108, 8'd103, 8'd69,  8'd98,  8'd55,  8'd74,  8'd78,
        8'd96,  8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,
        8'd72,  8'd73,  8'd82,  8'd83,  8'd86,  8'd127, 8'd116, 8'd117,
        8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190,
        8'd191, 8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
        8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
        8'd115, 8'd114, 8'd0,   8'd0,   8'd0,   8'd121, 8'd0,   8'd89,
        8'd93,  8'd124, 8'd92,  8'd94,  8'd95,  8'd0,   8'd0,   8'd0,
        8'd122, 8'd123, 8'd90,  8'd91,  8'd85,  8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd29,  8'd42,  8'd56,  8'd125, 8'd97,  8'd54,  8'd100, 8'd126,
        8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
        8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176,
        8'd142, 8'd152, 8'd173, 8'd140, 8'd0,   8'd0,   8'd0,   8'd0
    };

    function automatic logic [7:0] scan_to_key(input logic [7:0] scan);
        return SCAN_MAP[scan];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/kbd_state_ram.sv
`default_nettype none
module kbd_state_ram (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire logic            wr_en,
    input  wire kbd_pkg::slots_t wr_data,
    output kbd_pkg::slots_t      rd_data
);

    kbd_pkg::slots_t mem_row [0:0];
    kbd_pkg::slots_t rd_data_reg;
    logic            valid_reg;

    // single row; unwritten row reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_row[0] <= wr_data;
        end
    end

    // write-through on a same-cycle read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en)
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg)
            begin
                rd_data_reg <= mem_row[0];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hw/rtl/kbd_event_gen.sv
`default_nettype none
module kbd_event_gen (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire kbd_pkg::load_t ld,
    output logic                can_load,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [kbd_pkg::OUT_DATA_W-1:0] m_axis_tdata, // key_code, scan_code, key_down
    output logic [1:0]          m_axis_tuser,            // event_kind
    output logic                m_axis_tlast
);

    logic                         busy_reg, busy_next;
    logic [kbd_pkg::POS_W-1:0]    pos_reg, pos_next;
    kbd_pkg::load_t               rep_reg;

    logic                         out_valid_reg, out_valid_next;
    kbd_pkg::event_kind_t         out_kind_reg;
    logic [7:0]                   out_key_reg;
    logic [7:0]                   out_scan_reg;
    logic                         out_down_reg;
    logic                         out_last_reg;

    logic                         advance;
    logic                         at_end;
    logic [kbd_pkg::POS_W-1:0]    off;
    logic [kbd_pkg::SLOT_W-1:0]   idx;
    logic                         has_event;
    logic [7:0]                   ev_scan;
    logic                         ev_down;
    logic                         ev_sync;
    logic [7:0]                   ev_key;

    assign advance  = busy_reg && (!out_valid_reg || m_axis_tready);
    assign at_end   = (pos_reg == kbd_pkg::POS_W'(kbd_pkg::SYNC_POS));
    assign can_load = !busy_reg || (advance && at_end);

    assign off = pos_reg - kbd_pkg::POS_W'(kbd_pkg::MOD_COUNT);
    assign idx = off[kbd_pkg::SLOT_W:1];

    always_comb
    begin
        has_event = 1'b0;
        ev_scan   = 8'd0;
        ev_down   = 1'b0;
        ev_sync   = 1'b0;
        if (pos_reg < kbd_pkg::POS_W'(kbd_pkg::MOD_COUNT))
        begin
            has_event = 1'b1;
            ev_scan   = 8'(kbd_pkg::MOD_BASE)
                      + 8'(pos_reg[kbd_pkg::MOD_W-1:0]);
            ev_down   = rep_reg.mods[pos_reg[kbd_pkg::MOD_W-1:0]];
        end
        else if (!at_end)
        begin
            if (off[0])
            begin
                has_event = rep_reg.prs[idx];
                ev_scan   = rep_reg.new_keys[idx];
                ev_down   = 1'b1;
            end
            else
            begin
                has_event = rep_reg.rel[idx];
                ev_scan   = rep_reg.old_keys[idx];
            end
        end
        else
        begin
            has_event = 1'b1;
            ev_sync   = 1'b1;
        end
    end

    assign ev_key = kbd_pkg::scan_to_key(ev_scan);

    always_comb
    begin
        pos_next  = pos_reg;
        busy_next = busy_reg;
        if (load)
        begin
            pos_next  = '0;
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            pos_next  = pos_reg + 1'b1;
            busy_next = !at_end;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && has_event)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rep_reg <= ld;
        end
        if (advance && has_event)
        begin
            out_last_reg <= ev_sync;
            out_down_reg <= ev_down;
            if (ev_sync)
            begin
                out_kind_reg <= kbd_pkg::EV_SYNC;
                out_key_reg  <= 8'd0;
                out_scan_reg <= 8'd0;
            end
            else
            begin
                out_kind_reg <= (ev_key == 8'd0) ? kbd_pkg::EV_UNKNOWN : kbd_pkg::EV_KEY;
                out_key_reg  <= ev_key;
                out_scan_reg <= ev_scan;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_down_reg, out_scan_reg, out_key_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: hw/rtl/hid_keyboard_report_to_key_events.sv
// Boot keyboard report decoder.
// s_axis: one report per word. tdata carries modifier_bits and key slots
// a..f, tuser the transfer status. A nonzero status drops the word with no
// events and no change to the stored slots.
// m_axis: one key event per word. tdata carries key_code, scan_code and
// key_down, tuser the event kind, tlast marks the sync event that closes
// each good report.
// A report passes the input stage, then the generator, which registers
// each event it offers. The generator walks 8 modifier steps, two steps
// per key slot and one sync step, so a good report occupies it for every
// step however few events it yields; a dropped report leaves from the
// input stage. One further report is held there while the generator runs.
// The previous slots live in a one-row synchronous store, read on accept
// and written as a report enters the generator, with write-through.
// Reset empties both stages and makes the stored slots read as zero.
// A stall on m_axis freezes the generator; the input stage then fills
// and s_axis_tready drops.
`default_nettype none
module hid_keyboard_report_to_key_events (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [kbd_pkg::IN_DATA_W-1:0] s_axis_tdata, // modifier_bits, key_slot_a..f
    input  wire logic [1:0] s_axis_tuser,                    // transfer_status
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [kbd_pkg::OUT_DATA_W-1:0] m_axis_tdata, // key_code, scan_code, key_down
    output logic [1:0]      m_axis_tuser,                // event_kind
    output logic            m_axis_tlast
);

    logic            accept;
    kbd_pkg::slots_t in_keys;

    logic            s1_valid_reg, s1_valid_next;
    logic            s1_good_reg;
    logic [7:0]      s1_mods_reg;
    kbd_pkg::slots_t s1_keys_reg;

    kbd_pkg::slots_t old_keys;
    logic            can_load;
    logic            load;
    logic            drop;
    kbd_pkg::load_t  ld;

    for (genvar g = 0; g < kbd_pkg::KEY_SLOTS; g++)
    begin : g_in
        if (g < kbd_pkg::INPUT_SLOTS)
        begin : g_used
            assign in_keys[g] = s_axis_tdata[8 + 8 * g +: 8];
        end
        else
        begin : g_pad
            assign in_keys[g] = 8'd0;
        end
    end

    assign load          = s1_valid_reg && s1_good_reg && can_load;
    assign drop          = s1_valid_reg && !s1_good_reg;
    assign s_axis_tready = !s1_valid_reg || load || drop;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (load || drop)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_good_reg <= (s_axis_tuser == kbd_pkg::XFER_OK);
            s1_mods_reg <= s_axis_tdata[7:0];
            s1_keys_reg <= in_keys;
        end
    end

    kbd_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .wr_en   (load),
        .wr_data (s1_keys_reg),
        .rd_data (old_keys)
    );

    // release: old code above RESERVED_MAX gone from new report; press: new code above RESERVED_MAX not in old
    always_comb
    begin
        ld.mods     = s1_mods_reg;
        ld.old_keys = old_keys;
        ld.new_keys = s1_keys_reg;
        for (int i = 0; i < kbd_pkg::KEY_SLOTS; i++)
        begin
            ld.rel[i] = (old_keys[i] > 8'(kbd_pkg::RESERVED_MAX));
            ld.prs[i] = (s1_keys_reg[i] > 8'(kbd_pkg::RESERVED_MAX));
            for (int j = 0; j < kbd_pkg::KEY_SLOTS; j++)
            begin
                if (s1_keys_reg[j] == old_keys[i])
                begin
                    ld.rel[i] = 1'b0;
                end
                if (old_keys[j] == s1_keys_reg[i])
                begin
                    ld.prs[i] = 1'b0;
                end
            end
        end
    end

    kbd_event_gen u_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .ld            (ld),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: hw/rtl/kbd_checker.sv
`default_nettype none
module kbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [kbd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    a_last_sync: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == kbd_pkg::EV_SYNC)))
        else $error("tlast not on sync event");

    a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == kbd_pkg::EV_KEY) == (m_axis_tdata[7:0] != 8'd0)))
        else $error("key code inconsistent with event kind");

    a_sync_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == kbd_pkg::EV_SYNC |->
            m_axis_tdata[16:8] == 9'd0)
        else $error("sync event carries scan code or key_down");

endmodule

bind hid_keyboard_report_to_key_events kbd_checker u_kbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
